// ===== hdl/efc_pkg.sv =====
// shared types, widths and constants for the elevation flexure correction
`default_nettype none

package efc_pkg;

    // field widths
    localparam int ANG_W  = 31;
    localparam int TRIG_W = 32;
    localparam int COEF_W = 26;

    // internal widths
    localparam int PROD_W = COEF_W + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int CORR_W = SUM_W - 30;
    localparam int DIFF_W = ANG_W + 1;
    localparam int XY_W   = 43;
    localparam int Z_W    = 35;
    localparam int RND_W  = XY_W - 10;

    // default cordic length
    localparam int CORDIC_STAGES_DEF = 30;
    localparam int CORDIC_STAGES_MAX = 32;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SINE_COEFF   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COSINE_COEFF = 1'b1;

    // limits and constants
    localparam logic signed [DIFF_W-1:0] HALF_PI_POS  = 32'sd843314857;
    localparam logic signed [DIFF_W-1:0] HALF_PI_NEG  = -32'sd843314857;
    localparam logic signed [SUM_W-1:0]  CORR_HALF    = 59'sd536870912;
    localparam logic signed [XY_W-1:0]   GAIN_Q40     = 43'sd667681663043;
    localparam logic signed [XY_W-1:0]   OUT_HALF     = 43'sd512;
    localparam logic signed [RND_W-1:0]  ONE_Q30_POS  = 33'sd1073741824;
    localparam logic signed [RND_W-1:0]  ONE_Q30_NEG  = -33'sd1073741824;

    // atan(2^-i) in units of 2^-32 rad
    localparam logic [31:0] ATAN_TAB [CORDIC_STAGES_MAX] = '{
        32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
        32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
        32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
        32'd1048576,    32'd524288,     32'd262144,     32'd131072,
        32'd65536,      32'd32768,      32'd16384,      32'd8192,
        32'd4096,       32'd2048,       32'd1024,       32'd512,
        32'd256,        32'd128,        32'd64,         32'd32,
        32'd16,         32'd8,          32'd4,          32'd2
    };

    typedef logic signed [ANG_W-1:0]  t_ang;
    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [XY_W-1:0]   t_xy;
    typedef logic signed [Z_W-1:0]    t_z;

    // one cordic vector travelling down the pipeline
    typedef struct packed {
        t_xy  x;
        t_xy  y;
        t_z   z;
        t_ang ang;
    } t_cordic;

endpackage

`default_nettype wire

// ===== hdl/efc_flex.sv =====
// flexure term, subtraction from the elevation and clamp to +/- pi/2
`default_nettype none

module efc_flex (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire efc_pkg::t_coef i_sine_coeff,
    input  wire efc_pkg::t_coef i_cosine_coeff,
    input  wire logic           i_valid,
    input  wire efc_pkg::t_ang  i_elevation,
    input  wire efc_pkg::t_trig i_elev_sine,
    input  wire efc_pkg::t_trig i_elev_cosine,
    output logic                o_ready,
    input  wire logic           i_ready_dn,
    output logic                o_valid,
    output efc_pkg::t_ang       o_ang
);
    import efc_pkg::*;

    logic                       r_a_valid;
    logic                       r_b_valid;
    logic                       r_c_valid;
    logic                       w_ready_a;
    logic                       w_ready_b;
    logic                       w_ready_c;
    logic signed [PROD_W-1:0]   r_prod_s;
    logic signed [PROD_W-1:0]   r_prod_c;
    t_ang                       r_el_a;
    t_ang                       r_el_b;
    logic signed [CORR_W-1:0]   r_corr;
    t_ang                       r_ang;
    logic signed [PROD_W-1:0]   n_prod_s;
    logic signed [PROD_W-1:0]   n_prod_c;
    logic signed [SUM_W-1:0]    w_sum;
    logic signed [CORR_W-1:0]   n_corr;
    logic signed [DIFF_W-1:0]   w_diff;
    t_ang                       n_ang;

    // per-stage ready, bubbles collapse
    assign w_ready_c = !r_c_valid || i_ready_dn;
    assign w_ready_b = !r_b_valid || w_ready_c;
    assign w_ready_a = !r_a_valid || w_ready_b;
    assign o_ready   = w_ready_a;

    // stage a: two products
    always_comb begin
        n_prod_s = PROD_W'(i_sine_coeff) * PROD_W'(i_elev_sine);
        n_prod_c = PROD_W'(i_cosine_coeff) * PROD_W'(i_elev_cosine);
    end

    // stage b: exact sum, round half up to 2^-29 rad
    always_comb begin
        w_sum  = SUM_W'(r_prod_s) + SUM_W'(r_prod_c) + CORR_HALF;
        n_corr = w_sum[SUM_W-1:30];
    end

    // stage c: subtract and clamp
    always_comb begin
        w_diff = DIFF_W'(r_el_b) - DIFF_W'(r_corr);
        if (w_diff > HALF_PI_POS) begin
            n_ang = ANG_W'(HALF_PI_POS);
        end else if (w_diff < HALF_PI_NEG) begin
            n_ang = ANG_W'(HALF_PI_NEG);
        end else begin
            n_ang = w_diff[ANG_W-1:0];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_ready_a) r_a_valid <= i_valid;
            if (w_ready_b) r_b_valid <= r_a_valid;
            if (w_ready_c) r_c_valid <= r_b_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_ready_a) begin
            r_prod_s <= n_prod_s;
            r_prod_c <= n_prod_c;
            r_el_a   <= i_elevation;
        end
        if (w_ready_b) begin
            r_corr <= n_corr;
            r_el_b <= r_el_a;
        end
        if (w_ready_c) begin
            r_ang <= n_ang;
        end
    end

    assign o_valid = r_c_valid;
    assign o_ang   = r_ang;

endmodule

`default_nettype wire

// ===== hdl/efc_cordic_stage.sv =====
// one registered rotation-mode cordic iteration
`default_nettype none

module efc_cordic_stage #(
    parameter int STAGE = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire efc_pkg::t_cordic i_data,
    output logic                  o_ready,
    input  wire logic             i_ready_dn,
    output logic                  o_valid,
    output efc_pkg::t_cordic      o_data
);
    import efc_pkg::*;

    localparam t_z ATAN_Z = Z_W'(ATAN_TAB[STAGE]);

    logic    r_valid;
    t_cordic r_data;
    t_cordic n_data;
    t_xy     w_x;
    t_xy     w_y;
    t_z      w_z;
    t_xy     w_dx;
    t_xy     w_dy;

    assign o_ready = !r_valid || i_ready_dn;

    // rotate toward zero residual angle
    always_comb begin
        w_x  = i_data.x;
        w_y  = i_data.y;
        w_z  = i_data.z;
        w_dx = w_y >>> STAGE;
        w_dy = w_x >>> STAGE;
        n_data.ang = i_data.ang;
        if (!w_z[Z_W-1]) begin
            n_data.x = w_x - w_dx;
            n_data.y = w_y + w_dy;
            n_data.z = w_z - ATAN_Z;
        end else begin
            n_data.x = w_x + w_dx;
            n_data.y = w_y - w_dy;
            n_data.z = w_z + ATAN_Z;
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== hdl/efc_round.sv =====
// output register: round sine and cosine to q1.30 and clamp
`default_nettype none

module efc_round (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire efc_pkg::t_cordic i_data,
    output logic                  o_ready,
    input  wire logic             i_stall,
    output logic                  o_valid,
    output efc_pkg::t_ang         o_corrected_elevation,
    output efc_pkg::t_trig        o_corrected_sine,
    output efc_pkg::t_trig        o_corrected_cosine
);
    import efc_pkg::*;

    logic                    r_valid;
    t_ang                    r_ang;
    t_trig                   r_sine;
    t_trig                   r_cosine;
    t_trig                   n_sine;
    t_trig                   n_cosine;
    t_xy                     w_y_half;
    t_xy                     w_x_half;
    logic signed [RND_W-1:0] w_y_rnd;
    logic signed [RND_W-1:0] w_x_rnd;

    assign o_ready = !r_valid || !i_stall;

    // round half up by 2^10, then clamp to +/- 1.0
    always_comb begin
        w_y_half = i_data.y + OUT_HALF;
        w_x_half = i_data.x + OUT_HALF;
        w_y_rnd  = w_y_half[XY_W-1:10];
        w_x_rnd  = w_x_half[XY_W-1:10];
        if (w_y_rnd > ONE_Q30_POS) begin
            n_sine = TRIG_W'(ONE_Q30_POS);
        end else if (w_y_rnd < ONE_Q30_NEG) begin
            n_sine = TRIG_W'(ONE_Q30_NEG);
        end else begin
            n_sine = w_y_rnd[TRIG_W-1:0];
        end
        if (w_x_rnd > ONE_Q30_POS) begin
            n_cosine = TRIG_W'(ONE_Q30_POS);
        end else if (w_x_rnd < ONE_Q30_NEG) begin
            n_cosine = TRIG_W'(ONE_Q30_NEG);
        end else begin
            n_cosine = w_x_rnd[TRIG_W-1:0];
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_ang    <= i_data.ang;
            r_sine   <= n_sine;
            r_cosine <= n_cosine;
        end
    end

    assign o_valid               = r_valid;
    assign o_corrected_elevation = r_ang;
    assign o_corrected_sine      = r_sine;
    assign o_corrected_cosine    = r_cosine;

endmodule

`default_nettype wire

// ===== hdl/elevation_flexure_correction.sv =====
// top level of the elevation flexure correction pipeline
`default_nettype none

// Subtracts the flexure term sine_coeff*sin(el) + cosine_coeff*cos(el) from the
// elevation, clamps the result to +/- pi/2 and recomputes its sine and cosine
// with a CORDIC of CORDIC_STAGES iterations. One request is taken every cycle
// while a stage is free. Three stages form the products, the rounded correction
// and the clamp, then one register per CORDIC iteration and the output register.
// Each stage holds its own valid bit, so empty stages fill while the output is
// stalled, and a request is refused only when every stage is full. Coefficients
// are to be written through the configuration port while idle (not enforced).
module elevation_flexure_correction #(
    parameter int CORDIC_STAGES = efc_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [efc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [efc_pkg::COEF_W-1:0]        i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire efc_pkg::t_ang                     i_elevation,
    input  wire efc_pkg::t_trig                    i_elev_sine,
    input  wire efc_pkg::t_trig                    i_elev_cosine,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output efc_pkg::t_ang                          o_corrected_elevation,
    output efc_pkg::t_trig                         o_corrected_sine,
    output efc_pkg::t_trig                         o_corrected_cosine
);
    import efc_pkg::*;

    t_coef   r_sine_coeff;
    t_coef   r_cosine_coeff;
    logic    w_flex_ready;
    logic    w_flex_valid;
    t_ang    w_flex_ang;
    t_cordic w_link       [CORDIC_STAGES+1];
    logic    w_link_valid [CORDIC_STAGES+1];
    logic    w_link_ready [CORDIC_STAGES+1];

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sine_coeff   <= '0;
            r_cosine_coeff <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SINE_COEFF:   r_sine_coeff   <= i_cfg_data;
                REG_COSINE_COEFF: r_cosine_coeff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // flexure subtraction
    efc_flex u_flex (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sine_coeff   (r_sine_coeff),
        .i_cosine_coeff (r_cosine_coeff),
        .i_valid        (i_valid),
        .i_elevation    (i_elevation),
        .i_elev_sine    (i_elev_sine),
        .i_elev_cosine  (i_elev_cosine),
        .o_ready        (w_flex_ready),
        .i_ready_dn     (w_link_ready[0]),
        .o_valid        (w_flex_valid),
        .o_ang          (w_flex_ang)
    );

    assign o_stall = !w_flex_ready;

    // cordic seed: gain on x, angle scaled to 2^-32 rad
    always_comb begin
        w_link[0].x   = GAIN_Q40;
        w_link[0].y   = '0;
        w_link[0].z   = {w_flex_ang[ANG_W-1], w_flex_ang, 3'b000};
        w_link[0].ang = w_flex_ang;
    end
    assign w_link_valid[0] = w_flex_valid;

    // cordic iterations
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        efc_cordic_stage #(
            .STAGE (g)
        ) u_stage (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (w_link_valid[g]),
            .i_data     (w_link[g]),
            .o_ready    (w_link_ready[g]),
            .i_ready_dn (w_link_ready[g+1]),
            .o_valid    (w_link_valid[g+1]),
            .o_data     (w_link[g+1])
        );
    end

    // output register
    efc_round u_round (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (w_link_valid[CORDIC_STAGES]),
        .i_data                (w_link[CORDIC_STAGES]),
        .o_ready               (w_link_ready[CORDIC_STAGES]),
        .i_stall               (i_stall),
        .o_valid               (o_valid),
        .o_corrected_elevation (o_corrected_elevation),
        .o_corrected_sine      (o_corrected_sine),
        .o_corrected_cosine    (o_corrected_cosine)
    );

`ifndef ASSERT_OFF
    // an empty output stage means every stage can move, so no request is refused
    a_no_stall_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("request refused while output stage empty");

    // corrected angle stays inside the clamp
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (DIFF_W'(o_corrected_elevation) <= HALF_PI_POS) &&
                    (DIFF_W'(o_corrected_elevation) >= HALF_PI_NEG))
        else $error("corrected elevation outside +/- pi/2");

    // sine and cosine stay inside +/- 1.0
    a_trig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (RND_W'(o_corrected_sine) <= ONE_Q30_POS) &&
                    (RND_W'(o_corrected_sine) >= ONE_Q30_NEG) &&
                    (RND_W'(o_corrected_cosine) <= ONE_Q30_POS) &&
                    (RND_W'(o_corrected_cosine) >= ONE_Q30_NEG))
        else $error("sine or cosine outside +/- 1.0");
`endif

endmodule

`default_nettype wire

// ===== bench/elevation_flexure_correction_tb.sv =====
// self-checking testbench for the elevation flexure correction pipeline
module elevation_flexure_correction_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import efc_pkg::t_ang;
    import efc_pkg::t_trig;
    import efc_pkg::t_coef;

    localparam int          NUM_STAGES  = 30;
    localparam int          LATENCY     = NUM_STAGES + 4;
    localparam int          HOLD_CYCLES = 300;
    localparam int          CYCLE_LIMIT = 500000;
    localparam int          PHASE_ITEMS = 240;
    localparam int          REPORT_MAX  = 10;
    localparam longint      ELEV_LIMIT  = 64'sd843314857;
    localparam longint      ONE_Q30     = 64'sd1073741824;
    localparam longint      GAIN_Q40    = 64'sd667681663043;
    localparam int unsigned ELEV_SPAN   = 32'd1686629714;
    localparam int unsigned TRIG_SPAN   = 32'd2147483648;
    localparam int unsigned COEF_SPAN   = 32'd33554432;
    localparam t_coef       COEF_MAX    = 26'sh1FFFFFF;
    localparam t_coef       COEF_MIN    = 26'sh2000000;
    localparam t_coef       COEF_HIGH   = 26'sh1000000;
    localparam t_coef       COEF_LOW    = 26'sh3000000;

    // arctangent of 2^-i in units of 2^-32 rad
    localparam longint ARC_TAB [32] = '{
        64'sd3373259426, 1991351318, 1052175346, 534100635,
        268086748,  134174063,  67103403,   33553749,
        16777131,   8388597,    4194303,    2097152,
        1048576,    524288,     262144,     131072,
        65536,      32768,      16384,      8192,
        4096,       2048,       1024,       512,
        256,        128,        64,         32,
        16,         8,          4,          2
    };

    typedef struct packed {
        t_ang  elev;
        t_trig sine;
        t_trig cosine;
    } pointing_t;

    // predicts corrected pointing for each request and holds it until the result
    class corrected_pointing_book;
        pointing_t expected_q[$];
        longint    sine_coeff;
        longint    cosine_coeff;
        int        mismatches;
        int        requests_seen;
        int        results_seen;
        int        clamped_angles;

        function new();
            sine_coeff     = 0;
            cosine_coeff   = 0;
            mismatches     = 0;
            requests_seen  = 0;
            results_seen   = 0;
            clamped_angles = 0;
        endfunction

        function void set_coeffs(t_coef s, t_coef c);
            sine_coeff   = longint'($signed(s));
            cosine_coeff = longint'($signed(c));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function longint clamp64(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function void note_request(pointing_t req);
            longint    sum;
            longint    corr;
            longint    raw;
            longint    ang;
            longint    x;
            longint    y;
            longint    z;
            longint    dx;
            longint    dy;
            pointing_t want;
            // flexure term, rounded half up to 2^-29 rad
            sum  = sine_coeff * longint'($signed(req.sine))
                 + cosine_coeff * longint'($signed(req.cosine));
            corr = (sum + 64'sd536870912) >>> 30;
            raw  = longint'($signed(req.elev)) - corr;
            ang  = clamp64(raw, -ELEV_LIMIT, ELEV_LIMIT);
            if (ang != raw) clamped_angles++;
            // rotation-mode cordic, angle in 2^-32 rad, vector in 2^-40
            x = GAIN_Q40;
            y = 0;
            z = ang * 8;
            for (int i = 0; i < NUM_STAGES && i < 32; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ARC_TAB[i];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ARC_TAB[i];
                end
            end
            want.elev   = t_ang'(ang);
            want.sine   = t_trig'(clamp64((y + 64'sd512) >>> 10, -ONE_Q30, ONE_Q30));
            want.cosine = t_trig'(clamp64((x + 64'sd512) >>> 10, -ONE_Q30, ONE_Q30));
            expected_q.push_back(want);
            requests_seen++;
        endfunction

        function void check_result(pointing_t got);
            pointing_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result %0d with no request pending: elev %0d sine %0d cosine %0d",
                             results_seen, $signed(got.elev), $signed(got.sine),
                             $signed(got.cosine));
                return;
            end
            want = expected_q.pop_front();
            if (got.elev !== want.elev || got.sine !== want.sine
                    || got.cosine !== want.cosine) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("result %0d mismatch at %0t", results_seen, $realtime);
                    $display("  elev   exp %0d got %0d", $signed(want.elev), $signed(got.elev));
                    $display("  sine   exp %0d got %0d", $signed(want.sine), $signed(got.sine));
                    $display("  cosine exp %0d got %0d", $signed(want.cosine),
                             $signed(got.cosine));
                end
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_we      = 1'b0;
    logic [efc_pkg::CFG_IDX_W-1:0] i_cfg_index   = efc_pkg::REG_SINE_COEFF;
    logic [efc_pkg::COEF_W-1:0]    i_cfg_data    = '0;
    logic                          i_valid       = 1'b0;
    logic                          o_stall;
    t_ang                          i_elevation   = '0;
    t_trig                         i_elev_sine   = '0;
    t_trig                         i_elev_cosine = '0;
    logic                          o_valid;
    logic                          i_stall       = 1'b0;
    t_ang                          o_corrected_elevation;
    t_trig                         o_corrected_sine;
    t_trig                         o_corrected_cosine;

    corrected_pointing_book book;
    int          cycle_count     = 0;
    int          refused_cycles  = 0;
    int          coeff_settings  = 1;
    bit          hold_req        = 1'b0;
    bit          hold_taken      = 1'b0;
    int unsigned hold_left       = 0;
    int unsigned rx_left         = 0;
    int unsigned rx_mode         = 0;

    elevation_flexure_correction #(
        .CORDIC_STAGES(NUM_STAGES)
    ) dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_elevation           (i_elevation),
        .i_elev_sine           (i_elev_sine),
        .i_elev_cosine         (i_elev_cosine),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_corrected_elevation (o_corrected_elevation),
        .o_corrected_sine      (o_corrected_sine),
        .o_corrected_cosine    (o_corrected_cosine)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // result check, back-pressure count and run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && i_valid && o_stall) refused_cycles <= refused_cycles + 1;
        if (i_rst_n && o_valid && !i_stall)
            book.check_result('{elev: o_corrected_elevation, sine: o_corrected_sine,
                                cosine: o_corrected_cosine});
        if (cycle_count > CYCLE_LIMIT) begin
            $display("run limit of %0d cycles reached, %0d results outstanding",
                     CYCLE_LIMIT, book.pending());
            $display("** elevation_flexure_correction: FAILED **");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            i_stall    <= 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(0, 3);
                rx_left <= $urandom_range(4, 60);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 99) < 30);
                2: i_stall <= ($urandom_range(0, 99) < 80);
                default: i_stall <= 1'b1;
            endcase
        end
    end

    // offer one request and wait until it is taken
    task automatic send_request(t_ang el, t_trig s, t_trig c);
        i_valid       <= 1'b1;
        i_elevation   <= el;
        i_elev_sine   <= s;
        i_elev_cosine <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        book.note_request('{elev: el, sine: s, cosine: c});
    endtask

    // write both coefficients while the pipeline is empty
    task automatic write_coeffs(t_coef s, t_coef c);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= efc_pkg::REG_SINE_COEFF;
        i_cfg_data  <= s;
        @(posedge i_clk);
        i_cfg_index <= efc_pkg::REG_COSINE_COEFF;
        i_cfg_data  <= c;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        book.set_coeffs(s, c);
        coeff_settings++;
    endtask

    // stop offering and let every pending result come out
    task automatic drain();
        i_valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // mostly consistent angle/sine/cosine, some independent, some raw bits
    function automatic pointing_t random_pointing();
        pointing_t   p;
        int unsigned pick;
        longint      el;
        real         rad;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            if ($urandom_range(0, 9) == 0) begin
                el = ELEV_LIMIT - longint'($urandom_range(0, 4000));
                if ($urandom_range(0, 1) == 1) el = -el;
            end else begin
                el = longint'($urandom_range(0, ELEV_SPAN)) - ELEV_LIMIT;
            end
            rad      = real'(el) / 536870912.0;
            p.elev   = t_ang'(el);
            p.sine   = t_trig'($rtoi($sin(rad) * 1073741824.0));
            p.cosine = t_trig'($rtoi($cos(rad) * 1073741824.0));
        end else if (pick < 85) begin
            p.elev   = t_ang'(longint'($urandom_range(0, ELEV_SPAN)) - ELEV_LIMIT);
            p.sine   = t_trig'(longint'($urandom_range(0, TRIG_SPAN)) - ONE_Q30);
            p.cosine = t_trig'(longint'($urandom_range(0, TRIG_SPAN)) - ONE_Q30);
        end else begin
            p.elev   = t_ang'($urandom);
            p.sine   = t_trig'($urandom);
            p.cosine = t_trig'($urandom);
        end
        return p;
    endfunction

    // bursts of requests with random gaps, or back to back when steady
    task automatic run_random_phase(int unsigned count, bit steady);
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        pointing_t   req;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            for (int unsigned k = 0; k < burst && sent < count; k++) begin
                req = random_pointing();
                send_request(req.elev, req.sine, req.cosine);
                sent++;
            end
            gap = 0;
            if (!steady && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // main sequence
    initial begin
        t_coef sc;
        t_coef cc;
        book = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset coefficients: cordic alone, angle limits and field extremes
        send_request(t_ang'(0), t_trig'(0), t_trig'(ONE_Q30));
        send_request(t_ang'(ELEV_LIMIT), t_trig'(ONE_Q30), t_trig'(0));
        send_request(t_ang'(-ELEV_LIMIT), t_trig'(-ONE_Q30), t_trig'(0));
        send_request(t_ang'(ELEV_LIMIT - 1), t_trig'(0), t_trig'(0));
        send_request(t_ang'(31'sh3FFFFFFF), t_trig'(32'sh7FFFFFFF), t_trig'(32'sh80000000));
        send_request(t_ang'(31'sh40000000), t_trig'(32'sh80000000), t_trig'(32'sh7FFFFFFF));
        send_request(t_ang'(1), t_trig'(1), t_trig'(-1));
        send_request(t_ang'(-1), t_trig'(-1), t_trig'(1));
        drain();

        // extreme coefficients: largest flexure terms and saturation both ways
        write_coeffs(COEF_MAX, COEF_MIN);
        send_request(t_ang'(0), t_trig'(ONE_Q30), t_trig'(0));
        send_request(t_ang'(0), t_trig'(0), t_trig'(ONE_Q30));
        send_request(t_ang'(0), t_trig'(-ONE_Q30), t_trig'(-ONE_Q30));
        send_request(t_ang'(ELEV_LIMIT), t_trig'(32'sh7FFFFFFF), t_trig'(32'sh80000000));
        send_request(t_ang'(31'sh40000000), t_trig'(32'sh7FFFFFFF), t_trig'(32'sh80000000));
        send_request(t_ang'(31'sh3FFFFFFF), t_trig'(32'sh80000000), t_trig'(32'sh7FFFFFFF));
        send_request(t_ang'(0), t_trig'(0), t_trig'(0));
        send_request(t_ang'(-ELEV_LIMIT), t_trig'(ONE_Q30), t_trig'(ONE_Q30));
        drain();

        // unit coefficients: rounding of the correction at exactly one half
        write_coeffs(t_coef'(1), t_coef'(1));
        send_request(t_ang'(100), t_trig'(32'sh20000000), t_trig'(0));
        send_request(t_ang'(100), t_trig'(-32'sh20000000), t_trig'(0));
        send_request(t_ang'(100), t_trig'(32'sh1FFFFFFF), t_trig'(0));
        send_request(t_ang'(100), t_trig'(0), t_trig'(-32'sh20000001));
        drain();

        // random phases over a spread of coefficient settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin sc = '0;        cc = '0;        end
                1: begin sc = COEF_HIGH; cc = COEF_LOW;  end
                2: begin sc = COEF_LOW;  cc = COEF_HIGH; end
                3: begin sc = COEF_MIN;  cc = COEF_MAX;  end
                6: begin sc = t_coef'($urandom); cc = t_coef'($urandom); end
                7: begin sc = COEF_MAX;  cc = COEF_MAX;  end
                default: begin
                    sc = t_coef'(longint'($urandom_range(0, COEF_SPAN)) - 64'sd16777216);
                    cc = t_coef'(longint'($urandom_range(0, COEF_SPAN)) - 64'sd16777216);
                end
            endcase
            write_coeffs(sc, cc);
            // receiver holds off while requests keep coming, filling the pipeline
            if (ph == 2) hold_req <= 1'b1;
            run_random_phase(PHASE_ITEMS, ph == 2);
            drain();
        end

        $display("run covered %0d requests and %0d results over %0d coefficient settings",
                 book.requests_seen, book.results_seen, coeff_settings);
        $display("%0d corrected angles clamped, %0d cycles of refused input, %0d mismatches",
                 book.clamped_angles, refused_cycles, book.mismatches);
        if (book.mismatches == 0) begin
            $display("** elevation_flexure_correction: PASSED **");
        end else begin
            $display("** elevation_flexure_correction: FAILED **");
        end
        $finish;
    end

endmodule
